@@ rtl/core/tlbpc_pkg.sv @@
// Shared types and constants for the TLB lookup and page check core.
// Used by tlbpc_cell, tlbpc_chain and tlb_lookup_and_page_check_core.
`default_nettype none

package tlbpc_pkg;

  localparam int TlbEntries = 32;   // legal range 2..128
  localparam int PteW       = 25;   // entry bits 24:0 hold pfn and flags
  localparam int IdxW       = 5;

  localparam int FlagValid    = 0;
  localparam int FlagWritable = 1;
  localparam int FlagKernel   = 2;
  localparam int FlagGlobal   = 4;

  // configuration register indexes
  localparam logic CfgAsid   = 1'b0;
  localparam logic CfgPtBase = 1'b1;

  typedef enum logic [1:0] {
    KIND_XLATE = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_MISS     = 3'd1,
    STAT_INVALID  = 3'd2,
    STAT_KERNEL   = 3'd3,
    STAT_WRPROT   = 3'd4
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_WALK = 1'b1
  } fsm_e;

  typedef struct packed {
    logic [1:0]      kind;
    logic [31:0]     vaddr;
    logic            is_write;
    logic            user_mode;
    logic [31:0]     pc;
    logic [IdxW-1:0] entry_index;
    logic [63:0]     entry_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] phys_addr;
    logic [4:0]  pte_flags;
    logic [31:0] fault_addr;
    logic [31:0] fault_pc;
    logic        fault_is_write;
    logic [31:0] miss_tag;
    logic [31:0] pte_fetch_addr;
  } out_item_t;

  // Token moving down the row of cells.
  typedef struct packed {
    logic            active;
    logic            hit;
    logic [PteW-1:0] ent;
  } chain_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    logic [63:0]     value;
  } fill_t;

endpackage

`default_nettype wire

@@ rtl/core/tlbpc_cell.sv @@
// One TLB slot: holds a 64-bit entry and compares it against the lookup tag
// as the token passes. Depends on tlbpc_pkg.
`default_nettype none

module tlbpc_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_en_i,
  input  wire logic [63:0]        wr_data_i,
  input  wire logic [31:0]        tag_i,
  input  wire tlbpc_pkg::chain_t  prev_i,
  output tlbpc_pkg::chain_t       next_o
);

  logic [63:0]                 entry_q;
  logic                        match;
  tlbpc_pkg::chain_t           next_d;
  logic                        active_q;
  logic                        hit_q;
  logic [tlbpc_pkg::PteW-1:0]  ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (wr_en_i) begin
      entry_q <= wr_data_i;
    end
  end

  // global entries ignore the asid part of the tag
  always_comb begin
    if (entry_q[tlbpc_pkg::FlagGlobal]) begin
      match = (entry_q[51:32] == tag_i[19:0]);
    end else begin
      match = (entry_q[63:32] == tag_i);
    end
  end

  always_comb begin
    next_d = prev_i;
    if (prev_i.active && !prev_i.hit && match) begin
      next_d.hit = 1'b1;
      next_d.ent = entry_q[tlbpc_pkg::PteW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= next_d.active;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= next_d.hit;
    ent_q <= next_d.ent;
  end

  assign next_o = {active_q, hit_q, ent_q};

endmodule

`default_nettype wire

@@ rtl/core/tlbpc_chain.sv @@
// Row of TLB cells with fill decode; the lookup token walks one cell a cycle,
// lowest slot first. Depends on tlbpc_pkg and tlbpc_cell.
`default_nettype none

module tlbpc_chain (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tlbpc_pkg::fill_t   fill_i,
  input  wire logic [31:0]        tag_i,
  input  wire tlbpc_pkg::chain_t  head_i,
  output tlbpc_pkg::chain_t       tail_o
);

  localparam int N = tlbpc_pkg::TlbEntries;

  tlbpc_pkg::chain_t link [N+1];
  logic [N-1:0]      act_vec;
  logic [31:0]       idx_ext;

  assign idx_ext = 32'(fill_i.idx);
  assign link[0] = head_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic wr_en;
    // slots beyond the index range are never written
    assign wr_en      = fill_i.en && (idx_ext == 32'(i));
    assign act_vec[i] = link[i+1].active;

    tlbpc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_en_i   (wr_en),
      .wr_data_i (fill_i.value),
      .tag_i     (tag_i),
      .prev_i    (link[i]),
      .next_o    (link[i+1])
    );
  end

  assign tail_o = link[N];

  // only one lookup in flight
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(act_vec))
    else $error("more than one token in the cell row");

endmodule

`default_nettype wire

@@ rtl/core/tlb_lookup_and_page_check_core.sv @@
// Top level of the fully associative, software-refilled data TLB.
// Depends on tlbpc_pkg and tlbpc_chain.
//
// Usage:
//   An item is taken at a clock edge with start high and busy low. Kind 0
//   translates item_i.vaddr, kind 1 fills slot entry_index, kind 2 clears
//   the miss-pending flag, kind 3 does nothing.
//   Each item gives one result on result_o, marked by done_o for one cycle.
//   The receiver cannot stall; a result is simply presented once.
//   Fill, clear and kind 3: result in the cycle after acceptance, busy stays
//   low, so these items can be taken every cycle.
//   Translate: the lookup token walks the row of TLB_ENTRIES cells, one
//   cell per cycle, lowest slot first. busy stays high while the token
//   walks and falls as done_o is shown; the next item can be taken in the
//   cycle that done_o is shown, not before the walk of the last item ends.
//   Configuration (asid, page_table_base) is written through cfg_we_i with
//   no wait; the user must write it only while the block is idle, and the
//   block itself does not enforce this. Reset clears all entries, the miss
//   state and the configuration registers.
`default_nettype none

module tlb_lookup_and_page_check_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire tlbpc_pkg::in_item_t   item_i,
  output logic                       done_o,
  output tlbpc_pkg::out_item_t       result_o,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [11:0]           cfg_wdata_i
);

  tlbpc_pkg::fsm_e      state_q, state_d;
  logic                 launch_q, launch_d;
  logic                 accept;

  logic [11:0]          asid_q;
  logic [9:0]           ptb_q;

  logic                 pending_q, pending_d;
  logic [31:0]          saved_addr_q, saved_addr_d;
  logic [31:0]          saved_pc_q, saved_pc_d;
  logic                 last_wr_q, last_wr_d;
  logic [31:0]          rtag_q, rtag_d;

  // request held during the walk
  logic [31:0]          tag_q;
  logic [31:0]          vaddr_q;
  logic [31:0]          pc_q;
  logic                 wr_q;
  logic                 user_q;

  logic                 done_d;
  tlbpc_pkg::out_item_t res_q, res_d;

  tlbpc_pkg::fill_t     fill;
  tlbpc_pkg::chain_t    head, tail;

  assign busy   = (state_q == tlbpc_pkg::FSM_WALK);
  assign accept = start && !busy;

  assign fill.en    = accept && (item_i.kind == tlbpc_pkg::KIND_FILL);
  assign fill.idx   = item_i.entry_index;
  assign fill.value = item_i.entry_value;

  assign head.active = launch_q;
  assign head.hit    = 1'b0;
  assign head.ent    = '0;

  tlbpc_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fill_i (fill),
    .tag_i  (tag_q),
    .head_i (head),
    .tail_o (tail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asid_q <= '0;
      ptb_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlbpc_pkg::CfgAsid:   asid_q <= cfg_wdata_i;
        tlbpc_pkg::CfgPtBase: ptb_q  <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (item_i.kind == tlbpc_pkg::KIND_XLATE)) begin
      tag_q   <= {asid_q, item_i.vaddr[31:12]};
      vaddr_q <= item_i.vaddr;
      pc_q    <= item_i.pc;
      wr_q    <= item_i.is_write;
      user_q  <= item_i.user_mode;
    end
  end

  always_comb begin
    state_d      = state_q;
    launch_d     = 1'b0;
    done_d       = 1'b0;
    pending_d    = pending_q;
    saved_addr_d = saved_addr_q;
    saved_pc_d   = saved_pc_q;
    last_wr_d    = last_wr_q;
    rtag_d       = rtag_q;
    res_d        = '0;

    case (state_q)
      tlbpc_pkg::FSM_IDLE: begin
        if (accept) begin
          case (item_i.kind)
            tlbpc_pkg::KIND_XLATE: begin
              state_d  = tlbpc_pkg::FSM_WALK;
              launch_d = 1'b1;
            end
            tlbpc_pkg::KIND_CLEAR: begin
              pending_d = 1'b0;
              done_d    = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      tlbpc_pkg::FSM_WALK: begin
        if (tail.active) begin
          state_d = tlbpc_pkg::FSM_IDLE;
          done_d  = 1'b1;
          res_d.fault_addr     = vaddr_q;
          res_d.fault_pc       = pc_q;
          res_d.fault_is_write = wr_q;
          if (!tail.hit) begin
            res_d.status = tlbpc_pkg::STAT_MISS;
            rtag_d       = tag_q;
            last_wr_d    = wr_q;
            if (!pending_q) begin
              saved_addr_d = vaddr_q;
              saved_pc_d   = pc_q;
              pending_d    = 1'b1;
            end
          end else begin
            res_d.pte_flags = tail.ent[4:0];
            if (!tail.ent[tlbpc_pkg::FlagValid]) begin
              res_d.status = tlbpc_pkg::STAT_INVALID;
              // an invalid page reports the first pending miss, if any, with the write flag of the last miss
              if (pending_q) begin
                res_d.fault_addr     = saved_addr_q;
                res_d.fault_pc       = saved_pc_q;
                res_d.fault_is_write = last_wr_q;
                pending_d            = 1'b0;
              end
            end else if (tail.ent[tlbpc_pkg::FlagKernel] && user_q) begin
              res_d.status = tlbpc_pkg::STAT_KERNEL;
            end else if (wr_q && !tail.ent[tlbpc_pkg::FlagWritable]) begin
              res_d.status = tlbpc_pkg::STAT_WRPROT;
            end else begin
              res_d.status         = tlbpc_pkg::STAT_OK;
              res_d.phys_addr      = {tail.ent[24:5], vaddr_q[11:0]};
              res_d.fault_addr     = '0;
              res_d.fault_pc       = '0;
              res_d.fault_is_write = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d = tlbpc_pkg::FSM_IDLE;
      end
    endcase

    res_d.miss_tag       = rtag_d;
    res_d.pte_fetch_addr = {ptb_q, rtag_d[19:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tlbpc_pkg::FSM_IDLE;
      launch_q     <= 1'b0;
      done_o       <= 1'b0;
      pending_q    <= 1'b0;
      saved_addr_q <= '0;
      saved_pc_q   <= '0;
      last_wr_q    <= 1'b0;
      rtag_q       <= '0;
    end else begin
      state_q      <= state_d;
      launch_q     <= launch_d;
      done_o       <= done_d;
      pending_q    <= pending_d;
      saved_addr_q <= saved_addr_d;
      saved_pc_q   <= saved_pc_d;
      last_wr_q    <= last_wr_d;
      rtag_q       <= rtag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_o = res_q;

  a_walk_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("walk ended without a result");

  a_xlate_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (item_i.kind == tlbpc_pkg::KIND_XLATE)) |=> (busy && launch_q))
    else $error("translate item did not start a walk");

  a_tail_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.active |-> busy)
    else $error("token left the cell row while idle");

  a_launch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    launch_q |-> (busy && !tail.active))
    else $error("token launched outside a walk");

endmodule

`default_nettype wire

@@ dv/tb_tlb_lookup_and_page_check_core.sv @@
// Testbench for tlb_lookup_and_page_check_core: a queue-fed driver and a monitor
// that checks every result against a predictor of the TLB held in this file.
// Depends on tlbpc_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_tlb_lookup_and_page_check_core;
  import tlbpc_pkg::*;

  localparam logic [1:0] KindNop   = 2'd3;   // unused kind, no effect
  localparam int         PhaseLen  = 150;
  localparam int         SettleCyc = TlbEntries + 8;
  localparam int         CycLimit  = 200000;

  typedef struct packed {
    in_item_t item;
    int       gap;     // idle cycles after this item
    bit       drain;   // hold until all results are back
  } pend_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  in_item_t    item_i      = '0;
  logic        done_o;
  out_item_t   result_o;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = 1'b0;
  logic [11:0] cfg_wdata_i = '0;

  tlb_lookup_and_page_check_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // TLB state as predicted
  logic [63:0] tlb_slots [TlbEntries];
  logic        miss_pend;
  logic [31:0] saved_addr;
  logic [31:0] saved_pc;
  logic        saved_wr;
  logic [31:0] last_tag;
  logic [11:0] asid_r;
  logic [9:0]  ptb_r;

  pend_t       access_q[$];
  out_item_t   access_results_q[$];
  pend_t       head;
  out_item_t   want;
  int          hold_cnt;
  int          cyc_count;
  int          mismatches;
  int          items_taken;
  int          status_seen [5];
  logic [19:0] vpn_pool [16];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_item_t with_fault(out_item_t r, status_e st, logic [31:0] addr,
                                           logic [31:0] pcv, logic wr);
    r.status         = st;
    r.fault_addr     = addr;
    r.fault_pc       = pcv;
    r.fault_is_write = wr;
    return r;
  endfunction

  // Applies one item to the predicted TLB and returns the result it should give.
  function automatic out_item_t tlb_access(in_item_t it);
    out_item_t   r;
    logic [31:0] tag;
    logic [31:0] cmp_mask;
    logic [63:0] ent;
    logic        hit;
    r   = '0;
    hit = 1'b0;
    ent = '0;
    tag = {asid_r, it.vaddr[31:12]};
    case (it.kind)
      KIND_FILL: begin
        if (it.entry_index < TlbEntries) tlb_slots[it.entry_index] = it.entry_value;
      end
      KIND_CLEAR: begin
        miss_pend = 1'b0;
      end
      KIND_XLATE: begin
        // global entries compare the vpn only; lowest slot wins
        for (int i = 0; i < TlbEntries; i++) begin
          cmp_mask = tlb_slots[i][FlagGlobal] ? 32'h000F_FFFF : 32'hFFFF_FFFF;
          if (!hit && ((tlb_slots[i][63:32] & cmp_mask) == (tag & cmp_mask))) begin
            hit = 1'b1;
            ent = tlb_slots[i];
          end
        end
        if (!hit) begin
          last_tag = tag;
          saved_wr = it.is_write;
          if (!miss_pend) begin
            saved_addr = it.vaddr;
            saved_pc   = it.pc;
            miss_pend  = 1'b1;
          end
          r = with_fault(r, STAT_MISS, it.vaddr, it.pc, it.is_write);
        end else begin
          r.pte_flags = ent[4:0];
          if (!ent[FlagValid]) begin
            // invalid page reports the pending miss, if any, and retires it
            if (miss_pend) begin
              r = with_fault(r, STAT_INVALID, saved_addr, saved_pc, saved_wr);
              miss_pend = 1'b0;
            end else begin
              r = with_fault(r, STAT_INVALID, it.vaddr, it.pc, it.is_write);
            end
          end else if (ent[FlagKernel] && it.user_mode) begin
            r = with_fault(r, STAT_KERNEL, it.vaddr, it.pc, it.is_write);
          end else if (it.is_write && !ent[FlagWritable]) begin
            r = with_fault(r, STAT_WRPROT, it.vaddr, it.pc, it.is_write);
          end else begin
            r.phys_addr = {ent[24:5], it.vaddr[11:0]};
          end
        end
      end
      default: ;
    endcase
    r.miss_tag       = last_tag;
    r.pte_fetch_addr = {ptb_r, last_tag[19:0], 2'b00};
    return r;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.kind        = 2'($urandom_range(0, 3));
    it.vaddr       = $urandom;
    it.is_write    = 1'($urandom_range(0, 1));
    it.user_mode   = 1'($urandom_range(0, 1));
    it.pc          = $urandom;
    it.entry_index = IdxW'($urandom_range(0, 31));
    it.entry_value = {$urandom, $urandom};
    return it;
  endfunction

  function automatic in_item_t xlate_item(logic [31:0] va, logic wr, logic usr, logic [31:0] pcv);
    in_item_t it;
    it           = rand_item();
    it.kind      = KIND_XLATE;
    it.vaddr     = va;
    it.is_write  = wr;
    it.user_mode = usr;
    it.pc        = pcv;
    return it;
  endfunction

  function automatic in_item_t fill_item(logic [IdxW-1:0] idx, logic [63:0] val);
    in_item_t it;
    it             = rand_item();
    it.kind        = KIND_FILL;
    it.entry_index = idx;
    it.entry_value = val;
    return it;
  endfunction

  task automatic queue_item(in_item_t it, int gap, bit drain);
    pend_t p;
    p.item  = it;
    p.gap   = gap;
    p.drain = drain;
    access_q.push_back(p);
  endtask

  task automatic write_reg(logic idx, logic [11:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgAsid) asid_r = val;
    else ptb_r = val[9:0];
  endtask

  task automatic wait_idle();
    while (access_q.size() != 0 || start || busy || access_results_q.size() != 0)
      @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // Mostly fills and lookups over a small vpn pool so that hits, faults and
  // pending-miss handling all get exercised; some pure noise mixed in.
  task automatic gen_phase(int n);
    in_item_t    it;
    int          sel;
    bit          burst;
    logic [31:0] lo;
    logic [11:0] tag_asid;
    burst = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) burst = ($urandom_range(0, 2) == 0);
      it  = rand_item();
      sel = $urandom_range(0, 99);
      if (sel < 22) begin
        tag_asid = ($urandom_range(0, 3) != 0) ? asid_r : 12'($urandom_range(0, 4095));
        lo = $urandom;
        if ($urandom_range(0, 4) != 0) lo[FlagValid] = 1'b1;
        if ($urandom_range(0, 4) != 0) lo[FlagGlobal] = 1'b0;
        it = fill_item(it.entry_index,
                       {tag_asid, vpn_pool[$urandom_range(0, 15)], lo});
      end else if (sel < 80) begin
        it.kind = KIND_XLATE;
        if ($urandom_range(0, 3) != 0) it.vaddr[31:12] = vpn_pool[$urandom_range(0, 15)];
      end else if (sel < 92) begin
        it.kind = KIND_CLEAR;
      end else if (sel < 95) begin
        it.kind = KindNop;
      end
      queue_item(it, burst ? 0 : $urandom_range(0, 10),
                 (k == n / 2) || ($urandom_range(0, 99) == 0));
    end
  endtask

  // Driver: presents queued items, honoring gaps and drain holds.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (start && !busy) begin
        access_results_q.push_back(tlb_access(item_i));
        items_taken++;
      end
      if (!start || !busy) begin
        if (hold_cnt != 0) begin
          hold_cnt <= hold_cnt - 1;
          start    <= 1'b0;
        end else if (access_q.size() == 0) begin
          start <= 1'b0;
        end else if (access_q[0].drain && access_results_q.size() != 0) begin
          start <= 1'b0;
        end else begin
          head     = access_q.pop_front();
          item_i   <= head.item;
          start    <= 1'b1;
          hold_cnt <= head.gap;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Monitor: every strobed result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o !== 1'b0) begin
      if (access_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, result_o);
        mismatches++;
      end else begin
        want = access_results_q.pop_front();
        if (want.status < 5) status_seen[want.status]++;
        check_field("done_o", 1'b1, done_o);
        check_field("status", want.status, result_o.status);
        check_field("phys_addr", want.phys_addr, result_o.phys_addr);
        check_field("pte_flags", want.pte_flags, result_o.pte_flags);
        check_field("fault_addr", want.fault_addr, result_o.fault_addr);
        check_field("fault_pc", want.fault_pc, result_o.fault_pc);
        check_field("fault_is_write", want.fault_is_write, result_o.fault_is_write);
        check_field("miss_tag", want.miss_tag, result_o.miss_tag);
        check_field("pte_fetch_addr", want.pte_fetch_addr, result_o.pte_fetch_addr);
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count > CycLimit) begin
      $display("tb_tlb_lookup_and_page_check_core: done, errors");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    cyc_count   = 0;
    mismatches  = 0;
    items_taken = 0;
    for (int i = 0; i < 5; i++) status_seen[i] = 0;
    for (int i = 0; i < TlbEntries; i++) tlb_slots[i] = '0;
    miss_pend  = 1'b0;
    saved_addr = '0;
    saved_pc   = '0;
    saved_wr   = 1'b0;
    last_tag   = '0;
    asid_r     = '0;
    ptb_r      = '0;
    vpn_pool[0] = 20'h00000;
    vpn_pool[1] = 20'hFFFFF;
    for (int i = 2; i < 16; i++) vpn_pool[i] = 20'($urandom);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: cleared slots, miss pending and its retirement, each check
    queue_item(xlate_item(32'h0000_0000, 1'b0, 1'b0, 32'h0000_1000), 0, 1'b0);
    queue_item(xlate_item(32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF), 2, 1'b0);
    queue_item(xlate_item(32'h1234_5678, 1'b0, 1'b0, 32'h0000_2000), 0, 1'b0);
    queue_item(xlate_item(32'h0000_0ABC, 1'b0, 1'b1, 32'h0000_3000), 0, 1'b0);
    queue_item(fill_item(5'd0, {32'h0000_0001, 7'd0, 20'hFFFFF, 5'b00011}), 0, 1'b0);
    queue_item(xlate_item(32'h0000_1FFF, 1'b1, 1'b1, 32'h0000_4000), 0, 1'b0);
    queue_item(fill_item(5'd1, {32'h0000_0002, 7'd0, 20'h12345, 5'b00101}), 0, 1'b0);
    queue_item(xlate_item(32'h0000_2010, 1'b0, 1'b1, 32'h0000_5000), 3, 1'b0);
    queue_item(xlate_item(32'h0000_2020, 1'b0, 1'b0, 32'h0000_6000), 0, 1'b0);
    queue_item(xlate_item(32'h0000_2030, 1'b1, 1'b0, 32'h0000_7000), 0, 1'b0);
    queue_item(fill_item(5'd31, {12'hABC, 20'h00003, 7'd0, 20'h00ABC, 5'b10011}), 0, 1'b0);
    queue_item(xlate_item(32'h0000_3444, 1'b1, 1'b1, 32'h0000_8000), 0, 1'b0);
    queue_item(fill_item(5'd2, {12'hABC, 20'h00004, 7'd0, 20'h00001, 5'b00001}), 0, 1'b0);
    queue_item(xlate_item(32'h0000_4000, 1'b1, 1'b0, 32'h0000_9000), 0, 1'b1);
    it = rand_item();
    it.kind = KIND_CLEAR;
    queue_item(it, 1, 1'b0);
    queue_item(xlate_item(32'h0000_0FFF, 1'b1, 1'b0, 32'h0000_A000), 0, 1'b0);
    it = rand_item();
    it.kind = KindNop;
    queue_item(it, 0, 1'b0);
    queue_item(fill_item(5'd3, {32'h0000_0001, 7'h7F, 20'h55555, 5'b00011}), 0, 1'b0);
    queue_item(xlate_item(32'h0000_1555, 1'b0, 1'b0, 32'h0000_B000), 0, 1'b0);
    queue_item(fill_item(5'd31, 64'hFFFF_FFFF_FFFF_FFFF), 0, 1'b0);
    queue_item(xlate_item(32'hFFFF_F123, 1'b1, 1'b0, 32'h0000_C000), 0, 1'b0);
    queue_item(xlate_item(32'hFFFF_F000, 1'b0, 1'b1, 32'h0000_D000), 0, 1'b0);
    wait_idle();

    // random phases over several register settings, extremes first
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CfgAsid, 12'hFFF); write_reg(CfgPtBase, 12'hFFF); end
        1: begin write_reg(CfgAsid, 12'h000); write_reg(CfgPtBase, 12'h000); end
        2: begin write_reg(CfgAsid, 12'($urandom)); write_reg(CfgPtBase, 12'($urandom)); end
        3: begin write_reg(CfgAsid, 12'h001); write_reg(CfgPtBase, 12'hC00); end
        default: begin
          write_reg(CfgAsid, 12'($urandom));
          write_reg(CfgPtBase, 12'($urandom));
        end
      endcase
      for (int i = 2; i < 10; i++) vpn_pool[i] = 20'($urandom);
      gen_phase(PhaseLen);
      wait_idle();
    end

    $display("Run covered %0d items; lookups ok %0d, miss %0d, invalid %0d,",
             items_taken, status_seen[STAT_OK], status_seen[STAT_MISS],
             status_seen[STAT_INVALID]);
    $display("kernel faults %0d, write protect %0d, over 6 register settings.",
             status_seen[STAT_KERNEL], status_seen[STAT_WRPROT]);
    if (mismatches == 0 && access_results_q.size() == 0) begin
      $display("tb_tlb_lookup_and_page_check_core: done, clean");
    end else begin
      $display("tb_tlb_lookup_and_page_check_core: done, errors");
    end
    $finish;
  end

endmodule
